// ===== hw/rtl/depth_to_world_point_defines.svh =====
// depth_to_world_point_defines.svh
// Assertion macros for the depth_to_world_point block.
// Uses clk and rst_n of the module that includes it.
`ifndef DEPTH_TO_WORLD_POINT_DEFINES_SVH
`define DEPTH_TO_WORLD_POINT_DEFINES_SVH
`ifndef SYNTHESIS
`define D2WP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("d2wp check failed");
`define D2WP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("d2wp check failed");
`else
`define D2WP_ASSERT_IMP(lbl, ante, cons)
`define D2WP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/d2wp_pkg.sv =====
// d2wp_pkg.sv
// Widths, register indexes and reset values for depth_to_world_point.
// No dependencies.
package d2wp_pkg;

    localparam int COORD_BITS       = 18;
    localparam int PIXEL_INDEX_BITS = 12;

    localparam int DEPTH_W   = 16;
    localparam int Z_W       = 14;
    localparam int IFOC_W    = 24;
    localparam int CENTER_W  = 16;
    localparam int ROW_W     = 64;
    localparam int WIN_W     = 32;
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 64;

    localparam int PIPE_DEPTH = 7;

    localparam int CAM_SHIFT = 20;
    localparam int WLD_SHIFT = 22;
    localparam int CZ_SHIFT  = 8;

    localparam int U16_W  = PIXEL_INDEX_BITS + 4;
    localparam int DU_W   = ((U16_W > CENTER_W) ? U16_W : CENTER_W) + 1;
    localparam int PXZ_W  = DU_W + Z_W + 1;
    localparam int PF_W   = PXZ_W + IFOC_W + 1;
    localparam int CAM_W  = PF_W - CAM_SHIFT;
    localparam int PROD_W = CAM_W + COEF_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam int W_W    = ACC_W - WLD_SHIFT;

    localparam logic [DEPTH_W-1:0] DEPTH_MIN_MM = DEPTH_W'(50);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX_MM = DEPTH_W'(10000);

    localparam logic signed [PF_W-1:0]  CAM_RND = PF_W'(1) <<< (CAM_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] WLD_RND = ACC_W'(1) <<< (WLD_SHIFT - 1);

    localparam logic signed [W_W-1:0] SAT_HI =
        W_W'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    localparam logic signed [W_W-1:0] SAT_LO = -SAT_HI - W_W'(1);

    localparam logic [IFOC_W-1:0]   RST_INV_FOCAL_X = IFOC_W'(31956);
    localparam logic [IFOC_W-1:0]   RST_INV_FOCAL_Y = IFOC_W'(31956);
    localparam logic [CENTER_W-1:0] RST_CENTER_X    = CENTER_W'(5112);
    localparam logic [CENTER_W-1:0] RST_CENTER_Y    = CENTER_W'(3832);
    localparam logic [ROW_W-1:0]    RST_ROW_X       = 64'd16384;
    localparam logic [ROW_W-1:0]    RST_ROW_Y       = 64'd1073741824;
    localparam logic [ROW_W-1:0]    RST_ROW_Z       = 64'd70368744177664;
    localparam logic [WIN_W-1:0]    RST_Z_WINDOW    = 32'd72154636;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_FOCAL_X  = 4'd0,
        REG_INV_FOCAL_Y  = 4'd1,
        REG_CENTER_X     = 4'd2,
        REG_CENTER_Y     = 4'd3,
        REG_ROW_X        = 4'd4,
        REG_ROW_Y        = 4'd5,
        REG_ROW_Z        = 4'd6,
        REG_WORLD_Z_WIN  = 4'd7
    } cfg_reg_t;

endpackage

// ===== hw/rtl/depth_to_world_point.sv =====
// depth_to_world_point.sv
// Depth pixel to world point: pinhole back-projection, rigid transform, range checks.
// Depends on d2wp_pkg and depth_to_world_point_defines.svh.
// Pipeline: 7 register stages; stages stall independently, so bubbles fill.
// Throughput: one request per cycle while out_ready is high; a low out_ready stalls the stages.
// Reset clears all stage valid bits and loads the default calibration; cfg_ready is tied high.
`include "depth_to_world_point_defines.svh"

module depth_to_world_point (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [d2wp_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [d2wp_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [d2wp_pkg::DEPTH_W-1:0]             depth_mm,
    input  logic [d2wp_pkg::PIXEL_INDEX_BITS-1:0]    pixel_col,
    input  logic [d2wp_pkg::PIXEL_INDEX_BITS-1:0]    pixel_row,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [d2wp_pkg::COORD_BITS-1:0]   point_x,
    output logic signed [d2wp_pkg::COORD_BITS-1:0]   point_y,
    output logic signed [d2wp_pkg::COORD_BITS-1:0]   point_z,
    output logic                                     point_valid
);

    localparam int DU_W   = d2wp_pkg::DU_W;
    localparam int PXZ_W  = d2wp_pkg::PXZ_W;
    localparam int PF_W   = d2wp_pkg::PF_W;
    localparam int CAM_W  = d2wp_pkg::CAM_W;
    localparam int PROD_W = d2wp_pkg::PROD_W;
    localparam int ACC_W  = d2wp_pkg::ACC_W;
    localparam int W_W    = d2wp_pkg::W_W;
    localparam int Z_W    = d2wp_pkg::Z_W;
    localparam int NS     = d2wp_pkg::PIPE_DEPTH;

    // configuration registers
    logic [d2wp_pkg::IFOC_W-1:0]   inv_focal_x_reg, inv_focal_y_reg;
    logic [d2wp_pkg::CENTER_W-1:0] center_x_reg, center_y_reg;
    logic [d2wp_pkg::ROW_W-1:0]    row_reg [3];
    logic [d2wp_pkg::WIN_W-1:0]    z_window_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_focal_x_reg <= d2wp_pkg::RST_INV_FOCAL_X;
            inv_focal_y_reg <= d2wp_pkg::RST_INV_FOCAL_Y;
            center_x_reg    <= d2wp_pkg::RST_CENTER_X;
            center_y_reg    <= d2wp_pkg::RST_CENTER_Y;
            row_reg[0]      <= d2wp_pkg::RST_ROW_X;
            row_reg[1]      <= d2wp_pkg::RST_ROW_Y;
            row_reg[2]      <= d2wp_pkg::RST_ROW_Z;
            z_window_reg    <= d2wp_pkg::RST_Z_WINDOW;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (d2wp_pkg::cfg_reg_t'(cfg_index))
                d2wp_pkg::REG_INV_FOCAL_X: inv_focal_x_reg <= cfg_data[d2wp_pkg::IFOC_W-1:0];
                d2wp_pkg::REG_INV_FOCAL_Y: inv_focal_y_reg <= cfg_data[d2wp_pkg::IFOC_W-1:0];
                d2wp_pkg::REG_CENTER_X:    center_x_reg    <= cfg_data[d2wp_pkg::CENTER_W-1:0];
                d2wp_pkg::REG_CENTER_Y:    center_y_reg    <= cfg_data[d2wp_pkg::CENTER_W-1:0];
                d2wp_pkg::REG_ROW_X:       row_reg[0]      <= cfg_data;
                d2wp_pkg::REG_ROW_Y:       row_reg[1]      <= cfg_data;
                d2wp_pkg::REG_ROW_Z:       row_reg[2]      <= cfg_data;
                d2wp_pkg::REG_WORLD_Z_WIN: z_window_reg    <= cfg_data[d2wp_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valid bits and per-stage enables
    logic [NS:1] vld_reg, vld_next, en;

    always_comb
    begin
        en[NS] = !vld_reg[NS] || out_ready;
        for (int k = NS - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[1] = en[1] ? in_valid : vld_reg[1];
        for (int k = 2; k <= NS; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[1];
    assign out_valid = vld_reg[NS];

    logic [NS:1] load;
    assign load = en & {vld_reg[NS-1:1], in_valid};

    // stage 1: center offsets, depth range
    logic signed [DU_W-1:0] du_next, dv_next, du_reg, dv_reg;
    logic [Z_W-1:0] z1_reg;
    logic ok1_reg, ok1_next;

    assign du_next = signed'(DU_W'({pixel_col, 4'b0000})) - signed'(DU_W'(center_x_reg));
    assign dv_next = signed'(DU_W'({pixel_row, 4'b0000})) - signed'(DU_W'(center_y_reg));
    assign ok1_next = (depth_mm >= d2wp_pkg::DEPTH_MIN_MM) && (depth_mm <= d2wp_pkg::DEPTH_MAX_MM);

    // stage 2: offset times depth
    logic signed [PXZ_W-1:0] pxz_next, pyz_next, pxz_reg, pyz_reg;
    logic [Z_W-1:0] z2_reg;
    logic ok2_reg;

    assign pxz_next = du_reg * $signed({1'b0, z1_reg});
    assign pyz_next = dv_reg * $signed({1'b0, z1_reg});

    // stage 3: times inverse focal length
    logic signed [PF_W-1:0] pfx_next, pfy_next, pfx_reg, pfy_reg;
    logic [Z_W-1:0] z3_reg;
    logic ok3_reg;

    assign pfx_next = pxz_reg * $signed({1'b0, inv_focal_x_reg});
    assign pfy_next = pyz_reg * $signed({1'b0, inv_focal_y_reg});

    // stage 4: round to camera Q.8
    logic signed [PF_W-1:0]  pfx_rnd, pfy_rnd;
    logic signed [CAM_W-1:0] cam_next [3];
    logic signed [CAM_W-1:0] cam_reg [3];
    logic ok4_reg;

    assign pfx_rnd = pfx_reg + d2wp_pkg::CAM_RND;
    assign pfy_rnd = pfy_reg + d2wp_pkg::CAM_RND;
    assign cam_next[0] = $signed(pfx_rnd[PF_W-1:d2wp_pkg::CAM_SHIFT]);
    assign cam_next[1] = $signed(pfy_rnd[PF_W-1:d2wp_pkg::CAM_SHIFT]);
    assign cam_next[2] = signed'(CAM_W'({z3_reg, {d2wp_pkg::CZ_SHIFT{1'b0}}}));

    // stage 5: rotation products
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic ok5_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r][c] = $signed(row_reg[r][d2wp_pkg::COEF_W*c +: d2wp_pkg::COEF_W])
                                  * cam_reg[c];
            end
        end
    end

    // stage 6: sum, translate, round to mm
    logic signed [ACC_W-1:0] acc [3];
    logic signed [W_W-1:0]   w_next [3];
    logic signed [W_W-1:0]   w_reg [3];
    logic ok6_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = ACC_W'(prod_reg[r][0]) + ACC_W'(prod_reg[r][1]) + ACC_W'(prod_reg[r][2])
                     + (ACC_W'(signed'(row_reg[r][63:48])) <<< d2wp_pkg::WLD_SHIFT)
                     + d2wp_pkg::WLD_RND;
            w_next[r] = $signed(acc[r][ACC_W-1:d2wp_pkg::WLD_SHIFT]);
        end
    end

    // stage 7: window check, saturate, zero invalid points
    logic signed [W_W-1:0] zmin, zmax;
    logic win_ok, pv_next;
    logic signed [d2wp_pkg::COORD_BITS-1:0] sat [3];
    logic signed [d2wp_pkg::COORD_BITS-1:0] pt_next [3];
    logic signed [d2wp_pkg::COORD_BITS-1:0] pt_reg [3];
    logic pv_reg;

    assign zmin    = W_W'(signed'(z_window_reg[15:0]));
    assign zmax    = W_W'(signed'(z_window_reg[31:16]));
    assign win_ok  = (w_reg[2] >= zmin) && (w_reg[2] <= zmax);
    assign pv_next = ok6_reg && win_ok;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            if (w_reg[r] > d2wp_pkg::SAT_HI)
            begin
                sat[r] = d2wp_pkg::SAT_HI[d2wp_pkg::COORD_BITS-1:0];
            end
            else if (w_reg[r] < d2wp_pkg::SAT_LO)
            begin
                sat[r] = d2wp_pkg::SAT_LO[d2wp_pkg::COORD_BITS-1:0];
            end
            else
            begin
                sat[r] = w_reg[r][d2wp_pkg::COORD_BITS-1:0];
            end
            pt_next[r] = pv_next ? sat[r] : '0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            du_reg  <= du_next;
            dv_reg  <= dv_next;
            z1_reg  <= depth_mm[Z_W-1:0];
            ok1_reg <= ok1_next;
        end
        if (load[2])
        begin
            pxz_reg <= pxz_next;
            pyz_reg <= pyz_next;
            z2_reg  <= z1_reg;
            ok2_reg <= ok1_reg;
        end
        if (load[3])
        begin
            pfx_reg <= pfx_next;
            pfy_reg <= pfy_next;
            z3_reg  <= z2_reg;
            ok3_reg <= ok2_reg;
        end
        if (load[4])
        begin
            cam_reg <= cam_next;
            ok4_reg <= ok3_reg;
        end
        if (load[5])
        begin
            prod_reg <= prod_next;
            ok5_reg  <= ok4_reg;
        end
        if (load[6])
        begin
            w_reg   <= w_next;
            ok6_reg <= ok5_reg;
        end
        if (load[7])
        begin
            pt_reg <= pt_next;
            pv_reg <= pv_next;
        end
    end

    assign point_x     = pt_reg[0];
    assign point_y     = pt_reg[1];
    assign point_z     = pt_reg[2];
    assign point_valid = pv_reg;

    `D2WP_ASSERT_IMP(a_invalid_zero, out_valid && !point_valid, {point_x, point_y, point_z} == '0)
    `D2WP_ASSERT_NXT(a_accept_enters, in_valid && in_ready, vld_reg[1])
    `D2WP_ASSERT_IMP(a_full_stall, (&vld_reg) && !out_ready, !in_ready)
    `D2WP_ASSERT_NXT(a_drain_empty, out_valid && out_ready && !vld_reg[NS-1], !out_valid)

endmodule

// ===== sim/tb_depth_to_world_point.sv =====
// Self-checking testbench for depth_to_world_point: random and edge-case pixel requests
// under several calibrations, checked against an in-bench fixed-point deprojection.
// Depends on d2wp_pkg and the depth_to_world_point RTL.
module tb_depth_to_world_point;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS       = d2wp_pkg::COORD_BITS;
    localparam int PIXEL_INDEX_BITS = d2wp_pkg::PIXEL_INDEX_BITS;
    localparam int DEPTH_W          = d2wp_pkg::DEPTH_W;
    localparam int IFOC_W           = d2wp_pkg::IFOC_W;
    localparam int CENTER_W         = d2wp_pkg::CENTER_W;
    localparam int ROW_W            = d2wp_pkg::ROW_W;
    localparam int WIN_W            = d2wp_pkg::WIN_W;
    localparam int CFG_IDX_W        = d2wp_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W       = d2wp_pkg::CFG_DATA_W;
    localparam int CAM_SHIFT        = d2wp_pkg::CAM_SHIFT;
    localparam int WLD_SHIFT        = d2wp_pkg::WLD_SHIFT;
    localparam int CZ_SHIFT         = d2wp_pkg::CZ_SHIFT;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTED = 50;
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG_IDX = 4'd15;

    typedef struct packed {
        logic [DEPTH_W-1:0]          depth;
        logic [PIXEL_INDEX_BITS-1:0] col;
        logic [PIXEL_INDEX_BITS-1:0] row;
    } pixel_req_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic                         valid;
    } world_point_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [DEPTH_W-1:0]            depth_mm = '0;
    logic [PIXEL_INDEX_BITS-1:0]   pixel_col = '0;
    logic [PIXEL_INDEX_BITS-1:0]   pixel_row = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [COORD_BITS-1:0]  point_x;
    logic signed [COORD_BITS-1:0]  point_y;
    logic signed [COORD_BITS-1:0]  point_z;
    logic                          point_valid;

    // calibration as the block should hold it
    logic [IFOC_W-1:0]   cal_inv_fx;
    logic [IFOC_W-1:0]   cal_inv_fy;
    logic [CENTER_W-1:0] cal_center_x;
    logic [CENTER_W-1:0] cal_center_y;
    logic [ROW_W-1:0]    cal_row_x;
    logic [ROW_W-1:0]    cal_row_y;
    logic [ROW_W-1:0]    cal_row_z;
    logic [WIN_W-1:0]    cal_z_window;

    pixel_req_t   pending_pixels[$];
    world_point_t expected_points[$];

    int mismatches = 0;
    int pixels_sent = 0;
    int points_seen = 0;
    int valid_points = 0;
    int cal_writes = 0;
    int cal_settings = 1;
    int cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    logic [15:0] stall_pat = 16'hFFFF;
    logic [7:0]  pat_age = '0;

    depth_to_world_point dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .depth_mm   (depth_mm),
        .pixel_col  (pixel_col),
        .pixel_row  (pixel_row),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .point_valid(point_valid)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint rotate_row(logic [ROW_W-1:0] row, longint cx, longint cy,
                                          longint cz);
        longint acc;
        acc = longint'($signed(row[15:0])) * cx
            + longint'($signed(row[31:16])) * cy
            + longint'($signed(row[47:32])) * cz
            + (longint'($signed(row[63:48])) <<< WLD_SHIFT);
        return round_shift(acc, WLD_SHIFT);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint v);
        longint hi;
        hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
        if (v > hi)
            v = hi;
        else if (v < -hi - 1)
            v = -hi - 1;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic world_point_t deproject_point(pixel_req_t px);
        world_point_t pt;
        longint z, du, dv, cam_x, cam_y, cam_z, wx, wy, wz, zmin, zmax;
        pt = '0;
        if (px.depth >= d2wp_pkg::DEPTH_MIN_MM && px.depth <= d2wp_pkg::DEPTH_MAX_MM)
        begin
            z = longint'(px.depth);
            du = longint'(px.col) * 16 - longint'(cal_center_x);
            dv = longint'(px.row) * 16 - longint'(cal_center_y);
            cam_x = round_shift(du * z * longint'(cal_inv_fx), CAM_SHIFT);
            cam_y = round_shift(dv * z * longint'(cal_inv_fy), CAM_SHIFT);
            cam_z = z <<< CZ_SHIFT;
            wx = rotate_row(cal_row_x, cam_x, cam_y, cam_z);
            wy = rotate_row(cal_row_y, cam_x, cam_y, cam_z);
            wz = rotate_row(cal_row_z, cam_x, cam_y, cam_z);
            zmin = longint'($signed(cal_z_window[15:0]));
            zmax = longint'($signed(cal_z_window[31:16]));
            if (wz >= zmin && wz <= zmax)
            begin
                pt.x = clamp_coord(wx);
                pt.y = clamp_coord(wy);
                pt.z = clamp_coord(wz);
                pt.valid = 1'b1;
            end
        end
        return pt;
    endfunction

    function automatic void update_calibration(logic [CFG_IDX_W-1:0] idx,
                                               logic [CFG_DATA_W-1:0] data);
        case (idx)
            d2wp_pkg::REG_INV_FOCAL_X: cal_inv_fx = data[IFOC_W-1:0];
            d2wp_pkg::REG_INV_FOCAL_Y: cal_inv_fy = data[IFOC_W-1:0];
            d2wp_pkg::REG_CENTER_X:    cal_center_x = data[CENTER_W-1:0];
            d2wp_pkg::REG_CENTER_Y:    cal_center_y = data[CENTER_W-1:0];
            d2wp_pkg::REG_ROW_X:       cal_row_x = data;
            d2wp_pkg::REG_ROW_Y:       cal_row_y = data;
            d2wp_pkg::REG_ROW_Z:       cal_row_z = data;
            d2wp_pkg::REG_WORLD_Z_WIN: cal_z_window = data[WIN_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatches < MAX_PRINTED)
            $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    task automatic write_calibration(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        update_calibration(idx, data);
        cal_writes++;
    endtask

    task automatic load_calibration(logic [IFOC_W-1:0] ifx, logic [IFOC_W-1:0] ify,
                                    logic [CENTER_W-1:0] ctr_x, logic [CENTER_W-1:0] ctr_y,
                                    logic [ROW_W-1:0] rx, logic [ROW_W-1:0] ry,
                                    logic [ROW_W-1:0] rz, logic [WIN_W-1:0] win);
        write_calibration(d2wp_pkg::REG_INV_FOCAL_X, {$urandom, 8'($urandom), ifx});
        write_calibration(d2wp_pkg::REG_INV_FOCAL_Y, {$urandom, 8'($urandom), ify});
        write_calibration(d2wp_pkg::REG_CENTER_X, {$urandom, 16'($urandom), ctr_x});
        write_calibration(d2wp_pkg::REG_CENTER_Y, {$urandom, 16'($urandom), ctr_y});
        write_calibration(d2wp_pkg::REG_ROW_X, rx);
        write_calibration(d2wp_pkg::REG_ROW_Y, ry);
        write_calibration(d2wp_pkg::REG_ROW_Z, rz);
        write_calibration(d2wp_pkg::REG_WORLD_Z_WIN, {$urandom, win});
        write_calibration(UNUSED_REG_IDX, {$urandom, $urandom});
        cal_settings++;
    endtask

    task automatic wait_idle();
        while (pending_pixels.size() != 0 || in_valid || expected_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic queue_pixel(logic [DEPTH_W-1:0] d, logic [PIXEL_INDEX_BITS-1:0] c,
                               logic [PIXEL_INDEX_BITS-1:0] r);
        pending_pixels.push_back('{depth: d, col: c, row: r});
    endtask

    task automatic queue_random_pixels(int n);
        logic [DEPTH_W-1:0]          d;
        logic [PIXEL_INDEX_BITS-1:0] c, r;
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0: d = '0;
                1: d = DEPTH_W'($urandom_range(1, 49));
                2: d = DEPTH_W'($urandom_range(10001, 65535));
                3: d = DEPTH_W'($urandom_range(50, 400));
                default: d = DEPTH_W'($urandom_range(50, 10000));
            endcase
            c = PIXEL_INDEX_BITS'($urandom);
            r = PIXEL_INDEX_BITS'($urandom);
            if ($urandom_range(0, 15) == 0)
                c = $urandom_range(0, 1) ? '1 : '0;
            if ($urandom_range(0, 15) == 0)
                r = $urandom_range(0, 1) ? '1 : '0;
            queue_pixel(d, c, r);
        end
    endtask

    function automatic logic [ROW_W-1:0] plausible_row(int axis);
        logic [15:0] coef[3];
        for (int i = 0; i < 3; i++)
            coef[i] = 16'($signed($urandom_range(0, 32768)) - 16384);
        // keep the depth axis dominant so world z mostly lands in the window
        if (axis == 2)
            coef[2] = 16'($urandom_range(12000, 16384));
        return {16'($signed($urandom_range(0, 4000)) - 2000), coef[2], coef[1], coef[0]};
    endfunction

    task automatic load_random_calibration();
        logic [IFOC_W-1:0]  ifx, ify;
        logic [WIN_W-1:0]   win;
        logic [ROW_W-1:0]   rx, ry, rz;
        if ($urandom_range(0, 3) == 0)
        begin
            ifx = IFOC_W'($urandom);
            ify = IFOC_W'($urandom);
        end
        else
        begin
            ifx = IFOC_W'($urandom_range(4000, 200000));
            ify = IFOC_W'($urandom_range(4000, 200000));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            rx = {$urandom, $urandom};
            ry = {$urandom, $urandom};
            rz = {$urandom, $urandom};
        end
        else
        begin
            rx = plausible_row(0);
            ry = plausible_row(1);
            rz = plausible_row(2);
        end
        if ($urandom_range(0, 3) == 0)
            win = $urandom;
        else
            win = {16'($urandom_range(500, 32767)), 16'(-$signed($urandom_range(0, 3000)))};
        load_calibration(ifx, ify, 16'($urandom), 16'($urandom), rx, ry, rz, win);
    endtask

    // request driver: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic nxt_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_points.push_back(deproject_point('{depth: depth_mm, col: pixel_col,
                                                            row: pixel_row}));
                pixels_sent++;
            end
            if (!in_valid || in_ready)
            begin
                nxt_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending_pixels.size() != 0)
                begin
                    {depth_mm, pixel_col, pixel_row} <= pending_pixels.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 32);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                in_valid <= nxt_valid;
            end
        end
    end

    // result monitor; out_ready follows a rotating stall pattern reloaded whenever the 8-bit pattern age wraps
    always @(posedge clk or negedge rst_n)
    begin : monitor
        world_point_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_pat = 16'hFFFF;
            pat_age = '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                points_seen++;
                if (expected_points.size() == 0)
                    report_mismatch("unexpected point, x", longint'(point_x), 0);
                else
                begin
                    want = expected_points.pop_front();
                    if (point_x !== want.x)
                        report_mismatch("point_x", longint'(point_x), longint'(want.x));
                    if (point_y !== want.y)
                        report_mismatch("point_y", longint'(point_y), longint'(want.y));
                    if (point_z !== want.z)
                        report_mismatch("point_z", longint'(point_z), longint'(want.z));
                    if (point_valid !== want.valid)
                        report_mismatch("point_valid", longint'(point_valid),
                                        longint'(want.valid));
                    if (want.valid)
                        valid_points++;
                end
            end
            pat_age++;
            if (pat_age == 0)
            begin
                case ($urandom_range(0, 2))
                    0: stall_pat = 16'hFFFF;
                    1: stall_pat = 16'($urandom) | 16'h0001;
                    default: stall_pat = 16'($urandom) | 16'($urandom);
                endcase
            end
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            out_ready <= stall_pat[0];
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d points outstanding", cycles,
                     expected_points.size());
            $display("depth_to_world_point test failed");
            $finish;
        end
    end

    initial
    begin
        cal_inv_fx = d2wp_pkg::RST_INV_FOCAL_X;
        cal_inv_fy = d2wp_pkg::RST_INV_FOCAL_Y;
        cal_center_x = d2wp_pkg::RST_CENTER_X;
        cal_center_y = d2wp_pkg::RST_CENTER_Y;
        cal_row_x = d2wp_pkg::RST_ROW_X;
        cal_row_y = d2wp_pkg::RST_ROW_Y;
        cal_row_z = d2wp_pkg::RST_ROW_Z;
        cal_z_window = d2wp_pkg::RST_Z_WINDOW;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset calibration: depth limits, window edges, pixel corners
        queue_pixel(16'd0, 12'd0, 12'd0);
        queue_pixel(16'd0, 12'hFFF, 12'hFFF);
        queue_pixel(16'd1, 12'd100, 12'd100);
        queue_pixel(16'd49, 12'd320, 12'd240);
        queue_pixel(16'd50, 12'd0, 12'd0);
        queue_pixel(16'd50, 12'hFFF, 12'hFFF);
        queue_pixel(16'd1100, 12'd320, 12'd240);
        queue_pixel(16'd1101, 12'd320, 12'd240);
        queue_pixel(16'd10000, 12'd320, 12'd240);
        queue_pixel(16'd10001, 12'd320, 12'd240);
        queue_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
        queue_pixel(16'h8000, 12'd0, 12'hFFF);
        queue_pixel(16'd500, 12'd0, 12'd0);
        queue_pixel(16'd500, 12'hFFF, 12'd0);
        queue_pixel(16'd500, 12'd0, 12'hFFF);
        queue_pixel(16'd1000, 12'hFFF, 12'hFFF);
        queue_pixel(16'h0155, 12'hAAA, 12'h555);
        queue_pixel(16'h0AAA, 12'h555, 12'hAAA);
        queue_random_pixels(40);
        wait_idle();

        // largest focal terms and coefficients: x and y saturate in opposite directions
        load_calibration('1, '1, '0, '1,
                         {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
                         {16'h8000, 16'h8000, 16'h8000, 16'h8000},
                         {16'h0000, 16'h0000, 16'h0000, 16'h4000},
                         {16'h7FFF, 16'h8000});
        queue_pixel(16'd10000, 12'hFFF, 12'd0);
        queue_pixel(16'd10000, 12'd0, 12'hFFF);
        queue_pixel(16'd50, 12'hFFF, 12'hFFF);
        queue_pixel(16'd10000, 12'd0, 12'd0);
        queue_random_pixels(60);
        wait_idle();

        // zero inverse focal lengths
        load_calibration('0, '0, 16'd5112, 16'd3832, d2wp_pkg::RST_ROW_X, d2wp_pkg::RST_ROW_Y,
                         {16'd0, 16'h4000, 16'd0, 16'd0}, {16'h7FFF, 16'h8000});
        queue_random_pixels(40);
        wait_idle();

        // window minimum above maximum
        load_calibration(24'd31956, 24'd31956, 16'd5112, 16'd3832, d2wp_pkg::RST_ROW_X,
                         d2wp_pkg::RST_ROW_Y, d2wp_pkg::RST_ROW_Z, {16'h8000, 16'h7FFF});
        queue_random_pixels(30);
        wait_idle();

        repeat (6)
        begin
            load_random_calibration();
            queue_random_pixels(75);
            wait_idle();
        end

        repeat (d2wp_pkg::PIPE_DEPTH + 8) @(posedge clk);
        $display("%0d pixel requests, %0d points checked, %0d of them valid", pixels_sent,
                 points_seen, valid_points);
        $display("%0d calibration writes over %0d settings, %0d mismatches", cal_writes,
                 cal_settings, mismatches);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("depth_to_world_point test passed");
        else
            $display("depth_to_world_point test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/d2wp_pkg.sv
hw/rtl/depth_to_world_point.sv
sim/tb_depth_to_world_point.sv
